/* src/allm_pkg.sv */
// ----------------------------------------------------------------------------
// allm_pkg
// Shared types and constants of the array linked list manager: slot and value
// widths, operation and status codes, controller states and memory requests.
// ----------------------------------------------------------------------------
`default_nettype none

package allm_pkg;

    localparam int SLOTS      = 256;
    localparam int SLOT_W     = 8;
    localparam int VALUE_BITS = 32;
    localparam int PREV_W     = SLOT_W + 1;   // {in_use, prev link}

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_APPEND = 2'd1,
        OP_DELETE = 2'd2,
        OP_FIND   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_FULL       = 3'd1,
        ST_BAD_INSERT = 3'd2,
        ST_BAD_DELETE = 3'd3,
        ST_NOT_FOUND  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_RD1,
        S_RD2,
        S_WR1,
        S_WR2,
        S_FIND,
        S_FWAIT,
        S_DONE
    } state_t;

    // next link memory port
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [SLOT_W-1:0] wdata;
        logic [SLOT_W-1:0] raddr;
    } next_req_t;

    // prev link / in-use memory port
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [PREV_W-1:0] wdata;
        logic [SLOT_W-1:0] raddr;
    } prev_req_t;

    // value memory write port
    typedef struct packed {
        logic                  we;
        logic [SLOT_W-1:0]     waddr;
        logic [VALUE_BITS-1:0] wdata;
    } val_req_t;

    // finished request result
    typedef struct packed {
        logic              valid;
        status_t           status;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] head;
        logic [SLOT_W-1:0] tail;
    } result_t;

endpackage

`default_nettype wire

/* src/array_linked_list_manager_unit.sv */
// ----------------------------------------------------------------------------
// array_linked_list_manager_unit
// Doubly linked list kept in slot memories, with a free chain of unused slots.
// ----------------------------------------------------------------------------
// After reset the block clears its link memories, slot by slot, and takes no
// request; in_ready rises when that pass ends. Requests are then handled one
// at a time, each taking a few dependent accesses on the next link memory and
// the prev link memory (one write and one registered read per memory per
// cycle). Insert and append pass through S_RD1, S_RD2, S_WR1 and S_WR2, delete
// through S_RD1, S_WR1 and S_WR2; a full list or a delete of the sentinel goes
// straight to S_DONE, and an insert or delete on an unused slot stops after
// S_RD1. A find walks the list from the head until it reaches position or the
// end of the list; each hop waits for one next link read. The result sits in
// an output register, so the next request can be accepted while it waits.
`default_nettype none

module array_linked_list_manager_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [1:0]                           operation,
    input  wire logic [allm_pkg::SLOT_W-1:0]          slot,
    input  wire logic signed [allm_pkg::VALUE_BITS-1:0] value,
    input  wire logic [allm_pkg::SLOT_W-1:0]          position,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [2:0]                                status,
    output logic [allm_pkg::SLOT_W-1:0]               result_slot,
    output logic [allm_pkg::SLOT_W-1:0]               head,
    output logic [allm_pkg::SLOT_W-1:0]               tail
);

    import allm_pkg::*;

    next_req_t         next_req;
    prev_req_t         prev_req;
    val_req_t          val_req;
    logic [SLOT_W-1:0] next_rdata;
    logic [PREV_W-1:0] prev_rdata;
    result_t           done;
    logic              out_free;
    logic              out_valid_reg;
    status_t           status_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] head_reg;
    logic [SLOT_W-1:0] tail_reg;

    // next links
    allm_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_next_ram (
        .clk   (clk),
        .we    (next_req.we),
        .waddr (next_req.waddr),
        .wdata (next_req.wdata),
        .raddr (next_req.raddr),
        .rdata (next_rdata)
    );

    // prev links with in-use flag
    allm_ram #(
        .WIDTH (PREV_W),
        .DEPTH (SLOTS)
    ) u_prev_ram (
        .clk   (clk),
        .we    (prev_req.we),
        .waddr (prev_req.waddr),
        .wdata (prev_req.wdata),
        .raddr (prev_req.raddr),
        .rdata (prev_rdata)
    );

    // element values, written only
    allm_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (SLOTS)
    ) u_value_ram (
        .clk   (clk),
        .we    (val_req.we),
        .waddr (val_req.waddr),
        .wdata (val_req.wdata),
        .raddr (val_req.waddr),
        .rdata ()
    );

    allm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (op_t'(operation)),
        .slot       (slot),
        .value      (value),
        .position   (position),
        .next_req   (next_req),
        .next_rdata (next_rdata),
        .prev_req   (prev_req),
        .prev_rdata (prev_rdata),
        .val_req    (val_req),
        .done       (done),
        .out_free   (out_free)
    );

    assign out_free = !out_valid_reg || out_ready;

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done.valid && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (done.valid && out_free)
        begin
            status_reg <= done.status;
            slot_reg   <= done.slot;
            head_reg   <= done.head;
            tail_reg   <= done.tail;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign result_slot = slot_reg;
    assign head        = head_reg;
    assign tail        = tail_reg;

endmodule

`default_nettype wire

/* src/allm_ram.sv */
// ----------------------------------------------------------------------------
// allm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module allm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* src/allm_ctrl.sv */
// ----------------------------------------------------------------------------
// allm_ctrl
// Request sequencer: clears the link memories after reset, then runs each
// request as a series of link memory reads and, except for finds, writes.
// ----------------------------------------------------------------------------
`default_nettype none

module allm_ctrl (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire allm_pkg::op_t                     operation,
    input  wire logic [allm_pkg::SLOT_W-1:0]       slot,
    input  wire logic [allm_pkg::VALUE_BITS-1:0]   value,
    input  wire logic [allm_pkg::SLOT_W-1:0]       position,
    output allm_pkg::next_req_t                    next_req,
    input  wire logic [allm_pkg::SLOT_W-1:0]       next_rdata,
    output allm_pkg::prev_req_t                    prev_req,
    input  wire logic [allm_pkg::PREV_W-1:0]       prev_rdata,
    output allm_pkg::val_req_t                     val_req,
    output allm_pkg::result_t                      done,
    input  wire logic                              out_free
);

    import allm_pkg::*;

    state_t                state_reg, state_next;
    logic [SLOT_W-1:0]     cnt_reg, cnt_next;
    op_t                   op_reg, op_next;
    logic [SLOT_W-1:0]     at_reg, at_next;
    logic [SLOT_W-1:0]     cur_reg, cur_next;
    logic [SLOT_W-1:0]     pv_reg, pv_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [SLOT_W-1:0]     pos_reg, pos_next;
    logic [SLOT_W-1:0]     free_head_reg, free_head_next;
    logic [SLOT_W:0]       free_cnt_reg, free_cnt_next;
    logic [SLOT_W-1:0]     head_reg, head_next;
    logic [SLOT_W-1:0]     tail_reg, tail_next;
    status_t               st_reg, st_next;
    logic [SLOT_W-1:0]     res_reg, res_next;
    logic                  is_insert;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            free_head_reg <= SLOT_W'(1);
            free_cnt_reg  <= (SLOT_W+1)'(SLOTS - 1);
            head_reg      <= '0;
            tail_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            free_head_reg <= free_head_next;
            free_cnt_reg  <= free_cnt_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
        end
    end

    // request payload
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        at_reg  <= at_next;
        cur_reg <= cur_next;
        pv_reg  <= pv_next;
        val_reg <= val_next;
        pos_reg <= pos_next;
        st_reg  <= st_next;
        res_reg <= res_next;
    end

    assign is_insert = (op_reg == OP_INSERT) || (op_reg == OP_APPEND);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        at_next        = at_reg;
        cur_next       = cur_reg;
        pv_next        = pv_reg;
        val_next       = val_reg;
        pos_next       = pos_reg;
        free_head_next = free_head_reg;
        free_cnt_next  = free_cnt_reg;
        st_next        = st_reg;
        res_next       = res_reg;
        next_req       = '0;
        prev_req       = '0;
        val_req        = '0;
        in_ready       = 1'b0;
        done           = '0;

        unique case (state_reg)
            // clearing pass: free chain ascending, sentinel on itself
            S_INIT:
            begin
                next_req.we    = 1'b1;
                next_req.waddr = cnt_reg;
                next_req.wdata = ((cnt_reg == '0) || (cnt_reg == SLOT_W'(SLOTS - 1)))
                                 ? '0 : cnt_reg + SLOT_W'(1);
                prev_req.we    = 1'b1;
                prev_req.waddr = cnt_reg;
                prev_req.wdata = {(cnt_reg == '0), SLOT_W'(0)};
                cnt_next       = cnt_reg + SLOT_W'(1);
                if (cnt_reg == SLOT_W'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next  = operation;
                    val_next = value;
                    pos_next = position;
                    res_next = '0;
                    unique case (operation)
                        OP_INSERT, OP_APPEND:
                        begin
                            if (free_cnt_reg == '0)
                            begin
                                st_next    = ST_FULL;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                at_next        = (operation == OP_APPEND) ? tail_reg : slot;
                                next_req.raddr = at_next;
                                prev_req.raddr = at_next;
                                state_next     = S_RD1;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (slot == '0)
                            begin
                                st_next    = ST_BAD_DELETE;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                at_next        = slot;
                                next_req.raddr = slot;
                                prev_req.raddr = slot;
                                state_next     = S_RD1;
                            end
                        end
                        OP_FIND:
                        begin
                            cur_next   = head_reg;
                            cnt_next   = '0;
                            state_next = S_FIND;
                        end
                    endcase
                end
            end

            // links and in-use flag of the addressed slot arrive
            S_RD1:
            begin
                if (!prev_rdata[PREV_W-1])
                begin
                    st_next    = is_insert ? ST_BAD_INSERT : ST_BAD_DELETE;
                    state_next = S_DONE;
                end
                else if (is_insert)
                begin
                    cur_next       = next_rdata;       // follower
                    pv_next        = free_head_reg;    // fresh slot
                    next_req.raddr = free_head_reg;
                    state_next     = S_RD2;
                end
                else
                begin
                    cur_next   = next_rdata;               // next neighbor
                    pv_next    = prev_rdata[SLOT_W-1:0];   // previous neighbor
                    state_next = S_WR1;
                end
            end

            // pop the free chain
            S_RD2:
            begin
                free_head_next = next_rdata;
                free_cnt_next  = free_cnt_reg - (SLOT_W+1)'(1);
                state_next     = S_WR1;
            end

            // relink the neighbors
            S_WR1:
            begin
                next_req.we    = 1'b1;
                next_req.waddr = is_insert ? at_reg : pv_reg;
                next_req.wdata = is_insert ? pv_reg : cur_reg;
                prev_req.we    = 1'b1;
                prev_req.waddr = cur_reg;
                prev_req.wdata = {1'b1, pv_reg};
                state_next     = S_WR2;
            end

            // write the taken or freed slot itself
            S_WR2:
            begin
                next_req.we = 1'b1;
                prev_req.we = 1'b1;
                st_next     = ST_OK;
                if (is_insert)
                begin
                    next_req.waddr = pv_reg;
                    next_req.wdata = cur_reg;
                    prev_req.waddr = pv_reg;
                    prev_req.wdata = {1'b1, at_reg};
                    val_req.we     = 1'b1;
                    val_req.waddr  = pv_reg;
                    val_req.wdata  = val_reg;
                    res_next       = pv_reg;
                end
                else
                begin
                    next_req.waddr = at_reg;
                    next_req.wdata = free_head_reg;
                    prev_req.waddr = at_reg;
                    prev_req.wdata = '0;
                    free_head_next = at_reg;
                    free_cnt_next  = free_cnt_reg + (SLOT_W+1)'(1);
                end
                state_next = S_DONE;
            end

            // position search, one next link read per hop
            S_FIND:
            begin
                if (cur_reg == '0)
                begin
                    st_next    = ST_NOT_FOUND;
                    state_next = S_DONE;
                end
                else if (cnt_reg == pos_reg)
                begin
                    st_next    = ST_OK;
                    res_next   = cur_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    next_req.raddr = cur_reg;
                    state_next     = S_FWAIT;
                end
            end

            S_FWAIT:
            begin
                cur_next   = next_rdata;
                cnt_next   = cnt_reg + SLOT_W'(1);
                state_next = S_FIND;
            end

            S_DONE:
            begin
                done.valid  = 1'b1;
                done.status = st_reg;
                done.slot   = res_reg;
                done.head   = head_reg;
                done.tail   = tail_reg;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // sentinel links mirrored in registers
        head_next = (next_req.we && (next_req.waddr == '0)) ? next_req.wdata : head_reg;
        tail_next = (prev_req.we && (prev_req.waddr == '0)) ? prev_req.wdata[SLOT_W-1:0]
                                                             : tail_reg;
    end

endmodule

`default_nettype wire

/* src/allm_checker.sv */
// ----------------------------------------------------------------------------
// allm_checker
// Port-level checks of the array linked list manager, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module allm_checker (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    input  wire logic                                   in_ready,
    input  wire logic                                   out_valid,
    input  wire logic                                   out_ready,
    input  wire logic [2:0]                             status,
    input  wire logic [allm_pkg::SLOT_W-1:0]            result_slot,
    input  wire logic [allm_pkg::SLOT_W-1:0]            head,
    input  wire logic [allm_pkg::SLOT_W-1:0]            tail
);

    import allm_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(result_slot)
                                    && $stable(head) && $stable(tail))
        else $error("result changed while stalled");

    // failed requests report no slot
    a_fail_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> result_slot == '0)
        else $error("failed request returned a slot");

    // head and tail are empty together
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((head == '0) == (tail == '0)))
        else $error("head and tail disagree on empty list");

    // one request in work at a time
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while another is in work");

endmodule

bind array_linked_list_manager_unit allm_checker u_allm_checker (.*);

`default_nettype wire
